// ----- rtl/ddt_pkg.sv -----
// ----------------------------------------------------------------------------
// ddt_pkg
// Shared widths, limits and the control/status bundles of the drawdown tracker.
// ----------------------------------------------------------------------------
package ddt_pkg;

   localparam int TIME_BITS = 63;
   localparam int EQ_BITS   = 48;
   localparam int PCT_BITS  = 23;
   localparam int FRAC_BITS = 16;
   localparam int MUL_BITS  = 7;
   localparam int PROD_BITS = EQ_BITS + MUL_BITS;
   localparam int LOW_BITS  = PCT_BITS - FRAC_BITS;
   localparam int CNT_BITS  = $clog2(PCT_BITS + 1);

   localparam logic [MUL_BITS-1:0] PCT_MUL = MUL_BITS'(100);
   localparam logic [PCT_BITS-1:0] PCT_MAX = {PCT_BITS{1'b1}};

   typedef struct packed {
      logic capture;
      logic load;
      logic mul;
      logic prep;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

// ----- rtl/ddt_if.sv -----
// ----------------------------------------------------------------------------
// ddt_req_if / ddt_rsp_if
// Valid/ready channels for equity snapshots and drawdown results.
// ----------------------------------------------------------------------------
interface ddt_req_if
   import ddt_pkg::*;
;
   logic                        valid;
   logic                        ready;
   logic [TIME_BITS-1:0]        snap_time;
   logic signed [EQ_BITS-1:0]   equity_value;
   logic                        last_of_run;

   modport source (output valid, snap_time, equity_value, last_of_run, input ready);
   modport sink   (input valid, snap_time, equity_value, last_of_run, output ready);
endinterface

interface ddt_rsp_if
   import ddt_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [TIME_BITS-1:0]  point_time;
   logic [EQ_BITS-1:0]    drawdown_amount;
   logic [PCT_BITS-1:0]   drawdown_percent;
   logic [EQ_BITS-1:0]    worst_drawdown;
   logic [PCT_BITS-1:0]   worst_percent;
   logic [TIME_BITS-1:0]  longest_duration;
   logic                  summary_valid;

   modport source (output valid, point_time, drawdown_amount, drawdown_percent,
                   worst_drawdown, worst_percent, longest_duration, summary_valid,
                   input ready);
   modport sink   (input valid, point_time, drawdown_amount, drawdown_percent,
                   worst_drawdown, worst_percent, longest_duration, summary_valid,
                   output ready);
endinterface

// ----- rtl/ddt_ctrl.sv -----
// ----------------------------------------------------------------------------
// ddt_ctrl
// Sequencer: capture, peak update, scale, divide one bit a cycle, commit.
// ----------------------------------------------------------------------------
module ddt_ctrl
   import ddt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOAD   = 6'b000010,
      ST_MUL    = 6'b000100,
      ST_PREP   = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (stat.div_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.commit = stat.out_free;
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- rtl/ddt_datapath.sv -----
// ----------------------------------------------------------------------------
// ddt_datapath
// Run state, drawdown arithmetic, restoring divider and result register.
// ----------------------------------------------------------------------------
module ddt_datapath
   import ddt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   input  logic [TIME_BITS-1:0]      snap_time,
   input  logic signed [EQ_BITS-1:0] equity_value,
   input  logic                      last_of_run,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [TIME_BITS-1:0]      point_time,
   output logic [EQ_BITS-1:0]        drawdown_amount,
   output logic [PCT_BITS-1:0]       drawdown_percent,
   output logic [EQ_BITS-1:0]        worst_drawdown,
   output logic [PCT_BITS-1:0]       worst_percent,
   output logic [TIME_BITS-1:0]      longest_duration,
   output logic                      summary_valid
);

   function automatic logic [TIME_BITS-1:0] span_of(logic [TIME_BITS-1:0] t_end,
                                                    logic [TIME_BITS-1:0] t_begin);
      logic [TIME_BITS:0] diff;
      diff = {1'b0, t_end} - {1'b0, t_begin};
      return diff[TIME_BITS] ? '0 : diff[TIME_BITS-1:0];
   endfunction

   logic [TIME_BITS-1:0]      ts_ff;
   logic signed [EQ_BITS-1:0] eq_ff;
   logic                      last_ff;

   logic signed [EQ_BITS-1:0] peak_ff;
   logic                      started_ff;
   logic                      in_dd_ff;
   logic [TIME_BITS-1:0]      begin_ff;
   logic [EQ_BITS-1:0]        max_amt_ff;
   logic [PCT_BITS-1:0]       max_pct_ff;
   logic [TIME_BITS-1:0]      max_span_ff;

   logic [EQ_BITS-1:0]        dd_ff;
   logic                      pct_en_ff;
   logic [PROD_BITS-1:0]      prod_ff;
   logic [EQ_BITS-1:0]        rem_ff;
   logic [PCT_BITS-1:0]       low_ff;
   logic [PCT_BITS-1:0]       quo_ff;
   logic                      sat_ff;
   logic [CNT_BITS-1:0]       cnt_ff;

   logic                      rsp_valid_ff;
   logic [TIME_BITS-1:0]      point_time_ff;
   logic [EQ_BITS-1:0]        dd_out_ff;
   logic [PCT_BITS-1:0]       pct_out_ff;
   logic [EQ_BITS-1:0]        worst_amt_ff;
   logic [PCT_BITS-1:0]       worst_pct_ff;
   logic [TIME_BITS-1:0]      longest_ff;
   logic                      summary_ff;

   logic signed [EQ_BITS-1:0] peak_base;
   logic signed [EQ_BITS-1:0] peak_in;
   logic                      rise;
   logic [TIME_BITS-1:0]      span_now;
   logic [EQ_BITS-1:0]        dd_in;
   logic [EQ_BITS-1:0]        peak_u;
   logic [EQ_BITS-1:0]        rem_shift;
   logic                      rem_ge;
   logic [PCT_BITS-1:0]       pct_fin;
   logic                      amt_up;
   logic [EQ_BITS-1:0]        max_amt_in;
   logic [PCT_BITS-1:0]       max_pct_in;
   logic [TIME_BITS-1:0]      max_span_in;

   assign peak_base = started_ff ? peak_ff : eq_ff;
   assign rise      = eq_ff > peak_base;
   assign peak_in   = rise ? eq_ff : peak_base;
   assign dd_in     = $unsigned(peak_in - eq_ff);
   assign span_now  = span_of(ts_ff, begin_ff);

   assign peak_u    = $unsigned(peak_ff);
   assign rem_shift = {rem_ff[EQ_BITS-2:0], low_ff[PCT_BITS-1]};
   assign rem_ge    = rem_shift >= peak_u;

   assign pct_fin    = !pct_en_ff ? '0 : (sat_ff ? PCT_MAX : quo_ff);
   assign amt_up     = dd_ff > max_amt_ff;
   assign max_amt_in = amt_up ? dd_ff : max_amt_ff;
   assign max_pct_in = amt_up ? pct_fin : max_pct_ff;
   assign max_span_in = (last_ff && in_dd_ff && span_now > max_span_ff) ? span_now
                                                                       : max_span_ff;

   assign stat.div_last = (cnt_ff == CNT_BITS'(1));
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ts_ff   <= snap_time;
         eq_ff   <= equity_value;
         last_ff <= last_of_run;
      end
      if (cmd.load) begin
         dd_ff     <= dd_in;
         pct_en_ff <= !peak_in[EQ_BITS-1] && (peak_in != '0);
      end
      if (cmd.mul) begin
         prod_ff <= PROD_BITS'(dd_ff) * PROD_BITS'(PCT_MUL);
      end
      if (cmd.prep) begin
         rem_ff <= prod_ff[PROD_BITS-1:LOW_BITS];
         sat_ff <= prod_ff[PROD_BITS-1:LOW_BITS] >= peak_u;
         low_ff <= {prod_ff[LOW_BITS-1:0], {FRAC_BITS{1'b0}}};
         quo_ff <= '0;
      end
      if (cmd.step) begin
         rem_ff <= rem_ge ? rem_shift - peak_u : rem_shift;
         quo_ff <= {quo_ff[PCT_BITS-2:0], rem_ge};
         low_ff <= {low_ff[PCT_BITS-2:0], 1'b0};
      end
      if (cmd.commit) begin
         point_time_ff <= ts_ff;
         dd_out_ff     <= dd_ff;
         pct_out_ff    <= pct_fin;
         worst_amt_ff  <= max_amt_in;
         worst_pct_ff  <= max_pct_in;
         longest_ff    <= max_span_in;
         summary_ff    <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.prep) begin
         cnt_ff <= CNT_BITS'(PCT_BITS);
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff     <= '0;
         started_ff  <= 1'b0;
         in_dd_ff    <= 1'b0;
         begin_ff    <= '0;
         max_amt_ff  <= '0;
         max_pct_ff  <= '0;
         max_span_ff <= '0;
      end else if (cmd.load) begin
         peak_ff    <= peak_in;
         started_ff <= 1'b1;
         if (rise && in_dd_ff) begin
            in_dd_ff <= 1'b0;
            if (span_now > max_span_ff) max_span_ff <= span_now;
         end
      end else if (cmd.commit) begin
         if (last_ff) begin
            peak_ff     <= '0;
            started_ff  <= 1'b0;
            in_dd_ff    <= 1'b0;
            begin_ff    <= '0;
            max_amt_ff  <= '0;
            max_pct_ff  <= '0;
            max_span_ff <= '0;
         end else begin
            max_amt_ff <= max_amt_in;
            max_pct_ff <= max_pct_in;
            if (dd_ff != '0 && !in_dd_ff) begin
               begin_ff <= ts_ff;
               in_dd_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)           rsp_valid_ff <= 1'b0;
      else if (cmd.commit) rsp_valid_ff <= 1'b1;
      else if (rsp_ready)  rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign point_time       = point_time_ff;
   assign drawdown_amount  = dd_out_ff;
   assign drawdown_percent = pct_out_ff;
   assign worst_drawdown   = worst_amt_ff;
   assign worst_percent    = worst_pct_ff;
   assign longest_duration = longest_ff;
   assign summary_valid    = summary_ff;

endmodule

// ----- rtl/drawdown_tracker.sv -----
// ----------------------------------------------------------------------------
// drawdown_tracker
// A result beat follows its snapshot beat through the load, scale, prep, divide
// and commit states; a new snapshot is taken only after the previous one commits.
// The result register frees the input side while a result beat waits.
// Reset (synchronous, active high) clears the run state and the handshakes.
// ----------------------------------------------------------------------------
module drawdown_tracker
   import ddt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ddt_req_if.sink   req_bus,
   ddt_rsp_if.source rsp_bus
);

   cmd_type  cmd;
   stat_type stat;

   ddt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ddt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .snap_time        (req_bus.snap_time),
      .equity_value     (req_bus.equity_value),
      .last_of_run      (req_bus.last_of_run),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .point_time       (rsp_bus.point_time),
      .drawdown_amount  (rsp_bus.drawdown_amount),
      .drawdown_percent (rsp_bus.drawdown_percent),
      .worst_drawdown   (rsp_bus.worst_drawdown),
      .worst_percent    (rsp_bus.worst_percent),
      .longest_duration (rsp_bus.longest_duration),
      .summary_valid    (rsp_bus.summary_valid)
   );

endmodule

// ----- rtl/ddt_checker.sv -----
// ----------------------------------------------------------------------------
// ddt_checker
// Port-level checks of the drawdown tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ddt_checker
   import ddt_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [EQ_BITS-1:0]   drawdown_amount,
   input logic [PCT_BITS-1:0]  drawdown_percent,
   input logic [EQ_BITS-1:0]   worst_drawdown
);

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(drawdown_amount))
      else $error("result beat dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("snapshot taken while another is in flight");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_beat))
      else $error("result appeared one cycle after its snapshot");

   a_worst_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> drawdown_amount <= worst_drawdown)
      else $error("drawdown exceeds the worst drawdown");

   a_zero_pct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && drawdown_amount == '0 |-> drawdown_percent == '0)
      else $error("nonzero percent without a drawdown");

endmodule

bind drawdown_tracker ddt_checker u_ddt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .drawdown_amount  (rsp_bus.drawdown_amount),
   .drawdown_percent (rsp_bus.drawdown_percent),
   .worst_drawdown   (rsp_bus.worst_drawdown)
);
